// ----- hdl/dpb_pkg.sv -----
// ============================================================================
// dpb_pkg
// Shared types and constants of the depth pixel back-projection core.
// ============================================================================
package dpb_pkg;

    localparam int COLOR_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DENSE_MODE  = 3'd4;

    localparam logic [31:0] RST_PRINCIPAL_X = 32'd4096;
    localparam logic [31:0] RST_PRINCIPAL_Y = 32'd3392;
    localparam logic [31:0] RST_INV_FOCAL   = 32'd31030;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } dpb_adv_t;

endpackage

// ----- hdl/dpb_axis.sv -----
// ============================================================================
// dpb_axis
// Four-stage projection of one axis: offset, depth product, reciprocal
// product, then truncation and saturation to a signed 32-bit coordinate.
// ============================================================================
module dpb_axis
    import dpb_pkg::*;
#(
    parameter int COORD_BITS      = 12,
    parameter int DEPTH_BITS      = 16,
    parameter int RECIP_FRAC_BITS = 24
)
(
    input  logic                          clk,
    input  dpb_adv_t                      adv,
    input  logic [COORD_BITS-1:0]         pix,
    input  logic [COORD_BITS+3:0]         princ,
    input  logic [DEPTH_BITS-1:0]         depth,
    input  logic [RECIP_FRAC_BITS:0]      recip,
    output logic signed [POS_W-1:0]       pos
);

    localparam int PW     = COORD_BITS + 4;
    localparam int RW     = RECIP_FRAC_BITS + 1;
    localparam int PROD_W = PW + DEPTH_BITS;
    localparam int LO_W   = PROD_W + 16;
    localparam int HI_W   = PROD_W + RW - 16;
    localparam int SUM_W  = HI_W + 1;
    localparam int SHIFT  = RECIP_FRAC_BITS - 16;
    localparam int Q_W    = SUM_W - SHIFT;
    localparam int QX_W   = (Q_W > POS_W + 1) ? Q_W : POS_W + 1;

    logic [PW:0]             diff;
    logic                    neg_next;
    logic [PW-1:0]           mag_next;
    logic [PW-1:0]           mag_reg;
    logic [DEPTH_BITS-1:0]   depth_reg;
    logic                    neg1_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    neg2_reg;
    logic [LO_W-1:0]         lo_reg;
    logic [HI_W-1:0]         hi_reg;
    logic                    neg3_reg;
    logic [SUM_W-1:0]        sum;
    logic [QX_W-1:0]         q_ext;
    logic                    sat;
    logic [POS_W-1:0]        pos_next;
    logic [POS_W-1:0]        pos_reg;

    always_comb
    begin
        diff     = {1'b0, pix, 4'b0000} - {1'b0, princ};
        neg_next = diff[PW];
        mag_next = neg_next ? (~diff[PW-1:0] + 1'b1) : diff[PW-1:0];
    end

    always_comb
    begin
        sum   = SUM_W'(hi_reg) + SUM_W'(lo_reg[LO_W-1:16]);
        q_ext = QX_W'(sum >> SHIFT);
        sat   = |q_ext[QX_W-1:POS_W-1];
        if (neg3_reg)
        begin
            pos_next = sat ? {1'b1, {(POS_W-1){1'b0}}} : (~q_ext[POS_W-1:0] + 1'b1);
        end
        else
        begin
            pos_next = sat ? {1'b0, {(POS_W-1){1'b1}}} : q_ext[POS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.ld1)
        begin
            mag_reg   <= mag_next;
            neg1_reg  <= neg_next;
            depth_reg <= depth;
        end
        if (adv.ld2)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(depth_reg);
            neg2_reg <= neg1_reg;
        end
        if (adv.ld3)
        begin
            lo_reg   <= LO_W'(prod_reg) * LO_W'(recip[15:0]);
            hi_reg   <= HI_W'(prod_reg) * HI_W'(recip[RW-1:16]);
            neg3_reg <= neg2_reg;
        end
        if (adv.ld4)
        begin
            pos_reg <= pos_next;
        end
    end

    assign pos = $signed(pos_reg);

endmodule

// ----- hdl/depth_pixel_backprojection_core.sv -----
// ============================================================================
// depth_pixel_backprojection_core
// Pinhole back-projection of depth pixels into colored 3-D points.
// ============================================================================
//  Channel   Direction  Content
//  s_*       in         pixel word: column, row, depth_mm, red, green, blue
//  m_*       out        point word: position, color, source pixel; tuser valid
//  cfg_*     in         register writes, no read-back
//
//  One word is accepted per cycle while the first stage can take it; its result
//  passes through the four register stages of the two axis datapaths,
//  the last of which drives the output.
//  Each stage holds its word while the next one is full, so stalls lose nothing
//  and empty stages keep filling while the output waits.
//  Reset clears the stage valid bits and loads the default calibration.
// ============================================================================
module depth_pixel_backprojection_core
    import dpb_pkg::*;
#(
    parameter int COORD_BITS      = 12,
    parameter int DEPTH_BITS      = 16,
    parameter int RECIP_FRAC_BITS = 24,
    localparam int IN_W           = ((2 * COORD_BITS + DEPTH_BITS + 3 * 8 + 7) / 8) * 8,
    localparam int OUT_W          =
        ((2 * 32 + DEPTH_BITS + 4 + 3 * 8 + 2 * COORD_BITS + 7) / 8) * 8,
    localparam int CFG_W          =
        (COORD_BITS + 4 > RECIP_FRAC_BITS + 1) ? COORD_BITS + 4 : RECIP_FRAC_BITS + 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // column, row, depth_mm, red, green, blue
    input  logic [IN_W-1:0]         s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // pos_x, pos_y, pos_z, out_red, out_green, out_blue, out_column, out_row
    output logic [OUT_W-1:0]        m_tdata,
    // point_valid
    output logic                    m_tuser,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam int PW     = COORD_BITS + 4;
    localparam int RW     = RECIP_FRAC_BITS + 1;
    localparam int ZW     = DEPTH_BITS + 4;
    localparam int SIDE_W = 1 + ZW + 3 * COLOR_W + 2 * COORD_BITS;
    localparam int OFS_ROW = COORD_BITS;
    localparam int OFS_DEP = 2 * COORD_BITS;
    localparam int OFS_RED = OFS_DEP + DEPTH_BITS;
    localparam int OFS_GRN = OFS_RED + COLOR_W;
    localparam int OFS_BLU = OFS_GRN + COLOR_W;

    logic [PW-1:0]          principal_x_reg;
    logic [PW-1:0]          principal_y_reg;
    logic [RW-1:0]          inv_focal_x_reg;
    logic [RW-1:0]          inv_focal_y_reg;
    logic                   dense_mode_reg;

    logic [COORD_BITS-1:0]  in_col;
    logic [COORD_BITS-1:0]  in_row;
    logic [DEPTH_BITS-1:0]  in_depth;
    logic                   in_point_valid;
    logic [COLOR_W-1:0]     in_red;
    logic [COLOR_W-1:0]     in_green;
    logic [COLOR_W-1:0]     in_blue;
    logic [SIDE_W-1:0]      side_next;

    logic [4:1]             valid_reg;
    logic [SIDE_W-1:0]      side_reg [1:4];
    logic [4:1]             rdy;
    dpb_adv_t               adv;

    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            principal_x_reg <= PW'(RST_PRINCIPAL_X);
            principal_y_reg <= PW'(RST_PRINCIPAL_Y);
            inv_focal_x_reg <= RW'(RST_INV_FOCAL);
            inv_focal_y_reg <= RW'(RST_INV_FOCAL);
            dense_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRINCIPAL_X: principal_x_reg <= cfg_data[PW-1:0];
                REG_PRINCIPAL_Y: principal_y_reg <= cfg_data[PW-1:0];
                REG_INV_FOCAL_X: inv_focal_x_reg <= cfg_data[RW-1:0];
                REG_INV_FOCAL_Y: inv_focal_y_reg <= cfg_data[RW-1:0];
                REG_DENSE_MODE:  dense_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        in_col         = s_tdata[COORD_BITS-1:0];
        in_row         = s_tdata[OFS_ROW +: COORD_BITS];
        in_depth       = s_tdata[OFS_DEP +: DEPTH_BITS];
        in_point_valid = |in_depth;
        in_red         = in_point_valid ? s_tdata[OFS_RED +: COLOR_W] : '0;
        in_green       = in_point_valid ? s_tdata[OFS_GRN +: COLOR_W] : '0;
        in_blue        = in_point_valid ? s_tdata[OFS_BLU +: COLOR_W] : '0;
        side_next      = {in_row, in_col, in_blue, in_green, in_red,
                          in_depth, 4'b0000, in_point_valid};
    end

    assign rdy[4]   = !valid_reg[4] || m_tready;
    assign rdy[3]   = !valid_reg[3] || rdy[4];
    assign rdy[2]   = !valid_reg[2] || rdy[3];
    assign rdy[1]   = !valid_reg[1] || rdy[2];
    assign s_tready = rdy[1];
    assign adv      = '{ld1: rdy[1], ld2: rdy[2], ld3: rdy[3], ld4: rdy[4]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                valid_reg[1] <= s_tvalid && (in_point_valid || !dense_mode_reg);
            end
            if (rdy[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
            if (rdy[3])
            begin
                valid_reg[3] <= valid_reg[2];
            end
            if (rdy[4])
            begin
                valid_reg[4] <= valid_reg[3];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            side_reg[1] <= side_next;
        end
        if (rdy[2])
        begin
            side_reg[2] <= side_reg[1];
        end
        if (rdy[3])
        begin
            side_reg[3] <= side_reg[2];
        end
        if (rdy[4])
        begin
            side_reg[4] <= side_reg[3];
        end
    end

    dpb_axis #(
        .COORD_BITS      (COORD_BITS),
        .DEPTH_BITS      (DEPTH_BITS),
        .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
    ) u_axis_x (
        .clk   (clk),
        .adv   (adv),
        .pix   (in_col),
        .princ (principal_x_reg),
        .depth (in_depth),
        .recip (inv_focal_x_reg),
        .pos   (pos_x)
    );

    dpb_axis #(
        .COORD_BITS      (COORD_BITS),
        .DEPTH_BITS      (DEPTH_BITS),
        .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
    ) u_axis_y (
        .clk   (clk),
        .adv   (adv),
        .pix   (in_row),
        .princ (principal_y_reg),
        .depth (in_depth),
        .recip (inv_focal_y_reg),
        .pos   (pos_y)
    );

    assign m_tvalid = valid_reg[4];
    assign m_tuser  = side_reg[4][0];
    assign m_tdata  = OUT_W'({side_reg[4][SIDE_W-1:1], pos_y, pos_x});

endmodule
